>>> rtl/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types, codes and helpers for the hex record stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

  // Default longest line kept, in characters
  localparam int MAX_LINE_DEF = 1024;

  // Width used for length and position arithmetic (covers 2 * 255 + 11)
  localparam int LEN_W = 12;

  // Characters of interest
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] NIB_TEN  = 8'd10;

  // Record types
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_SEG = 8'h02;
  localparam logic [7:0] REC_START_S = 8'h03;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;
  localparam logic [7:0] REC_START_L = 8'h05;

  // Line status codes
  typedef enum logic [3:0] {
    ST_DATA_OK   = 4'd0,
    ST_EOF       = 4'd1,
    ST_EXT_OK    = 4'd2,
    ST_FORMAT    = 4'd3,
    ST_CHECKSUM  = 4'd4,
    ST_LENGTH    = 4'd5,
    ST_EMPTY     = 4'd6,
    ST_BAD_EXT   = 4'd7,
    ST_UNHANDLED = 4'd8,
    ST_UNKNOWN   = 4'd9
  } status_e;

  // Input command
  typedef enum logic {
    CMD_CHAR = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  // Result kind
  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // Registered input item with its decoded flags
  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  nibble;
    logic        is_cr;
    logic        is_lf;
    logic        is_colon;
  } char_t;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] byte_address;
    logic [7:0]  byte_value;
    status_e     line_status;
    logic [15:0] data_records;
    logic        finished;
  } result_t;

  // Hex digit value; anything else counts as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      v = c - CH_LA + NIB_TEN;
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - CH_UA + NIB_TEN;
    end
    return v[3:0];
  endfunction

endpackage

>>> rtl/hrsp_in_stage.sv
// ----------------------------------------------------------------------------
// hrsp_in_stage
// Input register: captures one transfer and pre-decodes the character.
// ----------------------------------------------------------------------------
module hrsp_in_stage import hrsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] ch_i,
  input  logic       adv_i,
  output logic       item_valid_o,
  output char_t      item_o
);

  logic  valid_q;
  char_t item_q;
  char_t item_d;

  // Hold while the held item cannot move on
  assign in_stall_o = valid_q && !adv_i;

  // Decode flags ahead of the register
  always_comb begin
    item_d.cmd      = cmd_e'(cmd_i);
    item_d.nibble   = nibble_of(ch_i);
    item_d.is_cr    = (ch_i == CH_CR);
    item_d.is_lf    = (ch_i == CH_LF);
    item_d.is_colon = (ch_i == CH_COLON);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/hrsp_line_core.sv
// ----------------------------------------------------------------------------
// hrsp_line_core
// Record state and per-character update; produces at most one result.
// ----------------------------------------------------------------------------
module hrsp_line_core import hrsp_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  char_t   item_i,
  input  logic    adv_i,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam int POS_W = $clog2(MAX_LINE + 1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [3:0]       hn_q, hn_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       bc_q, bc_d;
  logic [15:0]      raddr_q, raddr_d;
  logic [7:0]       rtype_q, rtype_d;
  logic [15:0]      upper_q, upper_d;
  logic [15:0]      pend_q, pend_d;
  logic [7:0]       didx_q, didx_d;
  logic             colon_q, colon_d;
  logic             eof_q, eof_d;
  logic [15:0]      recs_q, recs_d;
  logic             over_q, over_d;

  logic             fire;
  logic             do_status;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] bc2;
  logic [7:0]       b;
  logic [7:0]       idx;
  status_e          st;

  assign fire = item_valid_i && adv_i;
  assign len  = LEN_W'(pos_q);
  assign bc2  = {{(LEN_W-9){1'b0}}, bc_q, 1'b0};
  assign b    = {hn_q, item_i.nibble};
  assign idx  = 8'((len - LEN_W'(10)) >> 1);

  // Character handling and line judgement
  always_comb begin
    pos_d     = pos_q;
    hn_d      = hn_q;
    sum_d     = sum_q;
    bc_d      = bc_q;
    raddr_d   = raddr_q;
    rtype_d   = rtype_q;
    upper_d   = upper_q;
    pend_d    = pend_q;
    didx_d    = didx_q;
    colon_d   = colon_q;
    eof_d     = eof_q;
    recs_d    = recs_q;
    over_d    = over_q;
    do_status = 1'b0;
    st        = ST_FORMAT;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (fire && !eof_q) begin
      if (item_i.cmd == CMD_END) begin
        do_status = (pos_q != '0) || over_q;
      end else if (item_i.is_cr) begin
        // dropped
      end else if (item_i.is_lf) begin
        do_status = 1'b1;
      end else if (pos_q >= POS_W'(MAX_LINE)) begin
        over_d = 1'b1;
      end else begin
        pos_d = pos_q + POS_W'(1);
        if (pos_q == '0) begin
          colon_d = item_i.is_colon;
        end else if (pos_q[0]) begin
          hn_d = item_i.nibble;
        end else begin
          sum_d = sum_q + b;
          if (len == LEN_W'(2)) begin
            bc_d = b;
          end else if (len == LEN_W'(4)) begin
            raddr_d = {b, raddr_q[7:0]};
          end else if (len == LEN_W'(6)) begin
            raddr_d = {raddr_q[15:8], b};
          end else if (len == LEN_W'(8)) begin
            rtype_d = b;
          end else begin
            if (didx_q == 8'd0) begin
              pend_d = {b, pend_q[7:0]};
            end else if (didx_q == 8'd1) begin
              pend_d = {pend_q[15:8], b};
            end
            if (didx_q != 8'hFF) begin
              didx_d = didx_q + 8'd1;
            end
            // Tentative data byte
            if (colon_q && rtype_q == REC_DATA && len < LEN_W'(10) + bc2) begin
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_BYTE;
              res_o.byte_address = {upper_q, raddr_q} + 32'(idx);
              res_o.byte_value   = b;
              res_o.line_status  = ST_DATA_OK;
              res_o.data_records = recs_q;
              res_o.finished     = 1'b0;
            end
          end
        end
      end
    end

    // End of line: judge the record, then start a fresh line
    if (do_status) begin
      if (over_q) begin
        st = ST_LENGTH;
      end else if (!colon_q || !pos_q[0] || len < LEN_W'(11)) begin
        st = ST_FORMAT;
      end else if (sum_q != 8'd0) begin
        st = ST_CHECKSUM;
      end else if (len != bc2 + LEN_W'(11)) begin
        st = ST_LENGTH;
      end else begin
        case (rtype_q)
          REC_DATA: begin
            if (bc_q == 8'd0) begin
              st = ST_EMPTY;
            end else begin
              st = ST_DATA_OK;
              if (recs_q != 16'hFFFF) begin
                recs_d = recs_q + 16'd1;
              end
            end
          end
          REC_EOF: begin
            st    = ST_EOF;
            eof_d = 1'b1;
          end
          REC_EXT_LIN: begin
            if (raddr_q == 16'd0 && bc_q == 8'd2) begin
              st      = ST_EXT_OK;
              upper_d = pend_q;
            end else begin
              st = ST_BAD_EXT;
            end
          end
          REC_EXT_SEG, REC_START_S, REC_START_L: st = ST_UNHANDLED;
          default:                               st = ST_UNKNOWN;
        endcase
      end
      res_valid_o        = 1'b1;
      res_o.kind         = KIND_STATUS;
      res_o.byte_address = 32'd0;
      res_o.byte_value   = 8'd0;
      res_o.line_status  = st;
      res_o.data_records = recs_d;
      res_o.finished     = eof_d;
      pos_d   = '0;
      hn_d    = 4'd0;
      sum_d   = 8'd0;
      bc_d    = 8'd0;
      raddr_d = 16'd0;
      rtype_d = 8'd0;
      pend_d  = 16'd0;
      didx_d  = 8'd0;
      colon_d = 1'b0;
      over_d  = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hn_q    <= 4'd0;
      sum_q   <= 8'd0;
      bc_q    <= 8'd0;
      raddr_q <= 16'd0;
      rtype_q <= 8'd0;
      upper_q <= 16'd0;
      pend_q  <= 16'd0;
      didx_q  <= 8'd0;
      colon_q <= 1'b0;
      eof_q   <= 1'b0;
      recs_q  <= 16'd0;
      over_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      hn_q    <= hn_d;
      sum_q   <= sum_d;
      bc_q    <= bc_d;
      raddr_q <= raddr_d;
      rtype_q <= rtype_d;
      upper_q <= upper_d;
      pend_q  <= pend_d;
      didx_q  <= didx_d;
      colon_q <= colon_d;
      eof_q   <= eof_d;
      recs_q  <= recs_d;
      over_q  <= over_d;
    end
  end

endmodule

>>> rtl/hrsp_out_reg.sv
// ----------------------------------------------------------------------------
// hrsp_out_reg
// Result register: holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module hrsp_out_reg import hrsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    out_stall_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    adv_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // Free when empty or being taken this cycle
  assign adv_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/hex_record_stream_parser.sv
// ----------------------------------------------------------------------------
// hex_record_stream_parser
// Checks Intel HEX text one character per transfer and reports data bytes
// and one status per line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): cmd_i = 0 carries a text
//   character in ch_i, cmd_i = 1 closes any pending line at end of stream.
//   Output channel (out_valid_o / out_stall_i): kind_o = 0 is a tentative
//   data byte with its 32-bit address, kind_o = 1 the end-of-line status
//   that commits or rejects the bytes of that line.
//   Each character yields zero or one result. The character is held in the
//   input register, passes the record core and its result is loaded into the
//   result register, from which it is transferred when the receiver takes it.
//   Throughput is one character per cycle while the receiver does not
//   stall; the per-character record state update sets that rate.
//   When the receiver stalls with a result held, in_stall_o rises in the
//   same cycle if the input register holds a character, and that character
//   waits there; nothing is lost.
//   Reset clears all record state, the upper address, the record count and
//   the end-of-file flag. After a valid end-of-file record every further
//   transfer is taken and ignored.
// ----------------------------------------------------------------------------
module hex_record_stream_parser import hrsp_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [31:0] byte_address_o,
  output logic [7:0]  byte_value_o,
  output logic [3:0]  line_status_o,
  output logic [15:0] data_records_o,
  output logic        finished_o
);

  logic    adv;
  logic    item_valid;
  char_t   item;
  logic    res_valid;
  result_t res;
  result_t out_res;

  hrsp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .ch_i         (ch_i),
    .adv_i        (adv),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  hrsp_line_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .adv_i        (adv),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  hrsp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .out_stall_i (out_stall_i),
    .res_valid_i (res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign byte_address_o = out_res.byte_address;
  assign byte_value_o   = out_res.byte_value;
  assign line_status_o  = out_res.line_status;
  assign data_records_o = out_res.data_records;
  assign finished_o     = out_res.finished;

  // Input only backs up behind a held, stalled result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // Finished is only ever reported by the end-of-file status itself
  a_finished_eof : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> (kind_o && line_status_o == ST_EOF))
    else $error("finished flag outside an end-of-file status");

  // A data byte carries no status and no finished flag
  a_byte_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_o) |-> (line_status_o == ST_DATA_OK && !finished_o))
    else $error("data byte carries status bits");

endmodule
